// ===== design/wfa_pkg.sv =====
// ----------------------------------------------------------------------------
// wfa_pkg: wavefront switch allocator package
// Shared constants, transaction types and the cell-to-cell allocation state.
// ----------------------------------------------------------------------------
`default_nettype none

package wfa_pkg;

  // default configuration of the allocator
  localparam int NumPortsDef   = 5;
  localparam int NumClassesDef = 2;
  localparam int HomePort      = 0;
  localparam int RequestClass  = 0;

  // fixed field geometry of the transactions
  localparam int NumFields = 5;
  localparam int ReqW      = 25;
  localparam int CreditW   = 4;
  localparam int PrioW     = 3;
  localparam int SrcW      = 3;

  // largest supported port count, sizes the used-port vectors
  localparam int MaxPorts  = 8;
  localparam int MaxIdxW   = 3;

  // input transaction
  typedef struct packed {
    logic                 msg_class;
    logic [ReqW-1:0]      request_bits;
    logic [NumFields-1:0] input_active;
    logic [CreditW-1:0]   credit_home;
    logic [CreditW-1:0]   credit_port1;
    logic [CreditW-1:0]   credit_port2;
    logic [CreditW-1:0]   credit_port3;
    logic [CreditW-1:0]   credit_port4;
  } wfa_in_t;

  // output transaction
  typedef struct packed {
    logic [NumFields-1:0]      grant_valid;
    logic [NumFields*SrcW-1:0] grant_source;
  } wfa_out_t;

  // inputs and outputs already taken in this round
  typedef struct packed {
    logic [MaxPorts-1:0] row;
    logic [MaxPorts-1:0] col;
  } wfa_used_t;

endpackage

`default_nettype wire

// ===== design/wfa_diag_cell.sv =====
// ----------------------------------------------------------------------------
// wfa_diag_cell: one diagonal of the wavefront array
// Grants the requests of one diagonal against the inputs and outputs left
// free by the cells before it and hands the updated used vectors onward.
// ----------------------------------------------------------------------------
`default_nettype none

module wfa_diag_cell #(
  parameter int NumPorts = 5,
  localparam int DiagW   = (NumPorts > 1) ? $clog2(NumPorts) : 1
) (
  input  logic [DiagW-1:0]                 diag_i,
  input  logic [NumPorts-1:0][NumPorts-1:0] req_i,
  input  wfa_pkg::wfa_used_t               used_i,
  output wfa_pkg::wfa_used_t               used_o,
  output logic [NumPorts-1:0]              gnt_o,
  output logic [NumPorts-1:0][DiagW-1:0]   src_o,
  output logic                             any_o
);

  import wfa_pkg::*;

  localparam int SumW = DiagW + 2;

  // inputs on one diagonal all map to distinct outputs, so they are independent
  always_comb begin
    logic [SumW-1:0]  sum;
    logic [DiagW-1:0] y;
    logic             hit;
    used_o = used_i;
    gnt_o  = '0;
    src_o  = '0;
    any_o  = 1'b0;
    for (int x = 0; x < NumPorts; x++) begin
      sum = SumW'(diag_i) + SumW'(NumPorts) - SumW'(x);
      y   = (sum >= SumW'(NumPorts)) ? DiagW'(sum - SumW'(NumPorts)) : DiagW'(sum);
      hit = req_i[x][y] && !used_i.row[x] && !used_i.col[MaxIdxW'(y)];
      if (hit) begin
        used_o.row[x]             = 1'b1;
        used_o.col[MaxIdxW'(y)]   = 1'b1;
        gnt_o[y]                  = 1'b1;
        src_o[y]                  = DiagW'(x);
        any_o                     = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/wfa_out_buf.sv =====
// ----------------------------------------------------------------------------
// wfa_out_buf: result register with skid entry
// Holds the grant transaction for the output side and takes one more
// transaction while the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module wfa_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  wfa_pkg::wfa_out_t data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output wfa_pkg::wfa_out_t out_data_o
);

  import wfa_pkg::*;

  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  wfa_out_t out_q, out_d;
  wfa_out_t skid_q, skid_d;
  logic     take;

  assign take = out_valid_q && !out_stall_i;

  // main register refills from the skid entry first
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (wr_i) begin
        out_d = data_i;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (wr_i) begin
      if (!out_valid_q) begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  // control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload flops
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== design/wavefront_switch_allocator.sv =====
// ----------------------------------------------------------------------------
// wavefront_switch_allocator: per-class rotating wavefront switch allocator
// One transaction is one allocation round of one message class; the grant
// vector and the granted source per output come back registered.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload     handshake
//   in       input      wfa_in_t    in_valid_i / in_stall_o
//   out      output     wfa_out_t   out_valid_o / out_stall_i
//
// One transaction per cycle while the skid entry is free; the result is registered.
// The rate is set by the chain of NUM_PORTS diagonal cells, evaluated
// combinationally, and by the class priority register that feeds the next round.
// Reset clears every class priority to diagonal 0 and empties the output.
// A stalled output holds its result; one more round goes into the skid entry,
// and the input stalls while that entry is occupied.
`default_nettype none

module wavefront_switch_allocator #(
  parameter int NUM_PORTS   = wfa_pkg::NumPortsDef,
  parameter int NUM_CLASSES = wfa_pkg::NumClassesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  wfa_pkg::wfa_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output wfa_pkg::wfa_out_t out_data_o
);

  import wfa_pkg::*;

  localparam int DiagW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int ClsW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  logic [PrioW-1:0] prio_q [NUM_CLASSES];
  logic [DiagW-1:0] prio_d;
  logic             prio_wr;

  logic                               accept;
  logic                               cls_ok;
  logic                               is_req;
  logic [ClsW-1:0]                    cls_idx;
  logic [PrioW-1:0]                   prio_raw;
  logic [DiagW-1:0]                   diag [NUM_PORTS+1];
  logic [NumFields-1:0][CreditW-1:0]  credit;
  logic [NUM_PORTS-1:0]               elig;
  logic [NUM_PORTS-1:0][NUM_PORTS-1:0] req_eff;
  wfa_used_t                          used [NUM_PORTS+1];
  logic [NUM_PORTS-1:0]               cell_gnt [NUM_PORTS];
  logic [NUM_PORTS-1:0][DiagW-1:0]    cell_src [NUM_PORTS];
  logic [NUM_PORTS-1:0]               cell_any;
  logic [NumFields-1:0]               gv;
  logic [NumFields-1:0][SrcW-1:0]     gs;
  wfa_out_t                           res;

  // stored priority folded into the diagonal range
  function automatic logic [DiagW-1:0] prio_fold(input logic [PrioW-1:0] v);
    logic [PrioW-1:0] r;
    r = v;
    for (int i = 0; i < 4; i++) begin
      if (32'(r) >= NUM_PORTS) r = r - PrioW'(NUM_PORTS);
    end
    return DiagW'(r);
  endfunction

  assign accept   = in_valid_i && !in_stall_o;
  assign cls_ok   = 32'(in_data_i.msg_class) < NUM_CLASSES;
  assign is_req   = 32'(in_data_i.msg_class) == RequestClass;
  assign cls_idx  = ClsW'(in_data_i.msg_class);
  assign prio_raw = cls_ok ? prio_q[cls_idx] : '0;
  assign credit   = {in_data_i.credit_port4, in_data_i.credit_port3,
                     in_data_i.credit_port2, in_data_i.credit_port1,
                     in_data_i.credit_home};

  // output eligibility from credits; home output keeps one credit back for the request class
  for (genvar y = 0; y < NUM_PORTS; y++) begin : g_elig
    if (y < NumFields) begin : g_real
      logic [CreditW-1:0] thr;
      assign thr     = (is_req && (y == HomePort)) ? CreditW'(1) : '0;
      assign elig[y] = credit[y] > thr;
    end else begin : g_none
      assign elig[y] = 1'b0;
    end
  end

  // effective request matrix: active input, requested, eligible output
  for (genvar x = 0; x < NUM_PORTS; x++) begin : g_req_row
    for (genvar y = 0; y < NUM_PORTS; y++) begin : g_req_col
      if ((x < NumFields) && (x * NUM_PORTS + y < ReqW)) begin : g_real
        assign req_eff[x][y] = cls_ok && in_data_i.input_active[x] &&
                               in_data_i.request_bits[x * NUM_PORTS + y] && elig[y];
      end else begin : g_none
        assign req_eff[x][y] = 1'b0;
      end
    end
  end

  // diagonal visited by each cell, rotating from the class priority
  assign diag[0] = prio_fold(prio_raw);
  for (genvar s = 0; s < NUM_PORTS; s++) begin : g_diag
    assign diag[s+1] = (32'(diag[s]) == NUM_PORTS - 1) ? '0 : diag[s] + DiagW'(1);
  end

  // chain of diagonal cells
  assign used[0] = '0;
  for (genvar s = 0; s < NUM_PORTS; s++) begin : g_cell
    wfa_diag_cell #(
      .NumPorts (NUM_PORTS)
    ) u_cell (
      .diag_i (diag[s]),
      .req_i  (req_eff),
      .used_i (used[s]),
      .used_o (used[s+1]),
      .gnt_o  (cell_gnt[s]),
      .src_o  (cell_src[s]),
      .any_o  (cell_any[s])
    );
  end

  // merge cell grants per output, each output is granted at most once
  for (genvar y = 0; y < NumFields; y++) begin : g_merge
    if (y < NUM_PORTS) begin : g_real
      logic             v;
      logic [DiagW-1:0] src;
      always_comb begin
        v   = 1'b0;
        src = '0;
        for (int s = 0; s < NUM_PORTS; s++) begin
          v   = v | cell_gnt[s][y];
          src = src | (cell_src[s][y] & {DiagW{cell_gnt[s][y]}});
        end
      end
      assign gv[y] = v;
      assign gs[y] = SrcW'(src);
    end else begin : g_none
      assign gv[y] = 1'b0;
      assign gs[y] = '0;
    end
  end

  assign res.grant_valid  = gv;
  assign res.grant_source = gs;

  // new priority is the diagonal after the last one that granted
  always_comb begin
    prio_d  = diag[0];
    prio_wr = 1'b0;
    for (int s = 0; s < NUM_PORTS; s++) begin
      if (cell_any[s]) begin
        prio_d  = diag[s+1];
        prio_wr = 1'b1;
      end
    end
  end

  // class priority registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) prio_q[c] <= '0;
    end else if (accept && prio_wr) begin
      prio_q[cls_idx] <= PrioW'(prio_d);
    end
  end

  // result register and skid entry
  wfa_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (accept),
    .data_i      (res),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== design/wfa_checker.sv =====
// ----------------------------------------------------------------------------
// wfa_checker: port-level checks of the wavefront switch allocator
// Watches the transaction ports of the top level over time; bound below.
// ----------------------------------------------------------------------------
`default_nettype none

module wfa_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_o,
  input  logic              out_valid_o,
  input  logic              out_stall_i,
  input  wfa_pkg::wfa_out_t out_data_o
);

  import wfa_pkg::*;

  // no two granted outputs share a source input
  function automatic logic srcs_distinct(input wfa_out_t r);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < NumFields; i++) begin
      for (int j = i + 1; j < NumFields; j++) begin
        if (r.grant_valid[i] && r.grant_valid[j] &&
            (r.grant_source[i*SrcW +: SrcW] == r.grant_source[j*SrcW +: SrcW]))
          ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // ungranted outputs carry a zero source
  function automatic logic idle_srcs_zero(input wfa_out_t r);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < NumFields; i++) begin
      if (!r.grant_valid[i] && (r.grant_source[i*SrcW +: SrcW] != '0)) ok = 1'b0;
    end
    return ok;
  endfunction

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // after an accepted round the output is valid in the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted round gave no result");

  // input stalls only after the output backed up
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without output backpressure");

  // each input wins at most one output
  a_src_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> srcs_distinct(out_data_o))
    else $error("input granted to two outputs");

  // source fields of ungranted outputs are clear
  a_src_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> idle_srcs_zero(out_data_o))
    else $error("source set on ungranted output");

endmodule

bind wavefront_switch_allocator wfa_checker u_wfa_checker (.*);

`default_nettype wire

// ===== bench/tb_wavefront_switch_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wavefront_switch_allocator: self-checking bench for the switch allocator
// Drives allocation rounds over the valid/stall input channel and checks every
// result transaction against a typed-in grant or a local model of the rotating wavefront with
// per-class priority. A short directed table comes first, then random rounds
// under three idling mixes, with a long output hold-off and full drain pauses.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_wavefront_switch_allocator;
  import wfa_pkg::*;

  localparam int CycleLimit     = 400000;
  localparam int HoldCycles     = 64;
  localparam int RoundsPerPhase = 444;
  localparam int DrainCycles    = 8;

  // one directed round, with its grant typed in where it is obvious
  typedef struct {
    wfa_in_t  item;
    bit       typed;
    wfa_out_t grant;
  } dir_row_t;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  wfa_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  wfa_out_t out_data;

  // allocator state mirror and the grants still owed by the block
  logic [PrioW-1:0] class_prio [NumClassesDef];
  wfa_out_t         pending_grants [$];
  dir_row_t         dir_tab [$];

  bit       row_typed = 1'b0;
  wfa_out_t row_grant = '0;
  wfa_out_t want_grant;
  wfa_out_t pred_grant;
  int       mismatch_cnt = 0;
  int       cycle_cnt    = 0;
  int       in_idle_pct  = 0;
  int       out_idle_pct = 0;
  bit       hold_req     = 1'b0;
  int       hold_left    = 0;

  wavefront_switch_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // one wavefront round: diagonals from the class priority, inputs in order
  function automatic wfa_out_t allocate_round(input wfa_in_t rq);
    wfa_out_t               res;
    logic [NumPortsDef-1:0] row_taken;
    logic [NumPortsDef-1:0] col_taken;
    logic [CreditW-1:0]     credit [NumPortsDef];
    int                     cls;
    int                     diag;
    int                     s;
    int                     x;
    int                     y;
    int                     floor_cr;
    res       = '0;
    row_taken = '0;
    col_taken = '0;
    credit[0] = rq.credit_home;
    credit[1] = rq.credit_port1;
    credit[2] = rq.credit_port2;
    credit[3] = rq.credit_port3;
    credit[4] = rq.credit_port4;
    cls = int'(rq.msg_class);
    // class out of range grants nothing and keeps every priority
    if (cls >= NumClassesDef) return res;
    diag = int'(class_prio[cls]) % NumPortsDef;
    for (s = 0; s < NumPortsDef; s++) begin
      for (x = 0; x < NumPortsDef; x++) begin
        y = (diag + NumPortsDef - x) % NumPortsDef;
        // request class needs more than one credit at the home output
        floor_cr = (cls == RequestClass && y == HomePort) ? 1 : 0;
        if (rq.input_active[x] && rq.request_bits[x*NumPortsDef+y] &&
            !row_taken[x] && !col_taken[y] && int'(credit[y]) > floor_cr) begin
          row_taken[x] = 1'b1;
          col_taken[y] = 1'b1;
          res.grant_valid[y] = 1'b1;
          res.grant_source[SrcW*y +: SrcW] = SrcW'(x);
          class_prio[cls] = PrioW'((diag + 1) % NumPortsDef);
        end
      end
      diag = (diag + 1) % NumPortsDef;
    end
    return res;
  endfunction

  // credits leaning toward the threshold values
  function automatic logic [CreditW-1:0] pick_credit();
    if ($urandom_range(3) == 0) return CreditW'($urandom_range(2));
    return CreditW'($urandom_range(15));
  endfunction

  function automatic wfa_in_t rand_round();
    wfa_in_t it;
    it.msg_class = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: it.request_bits = ReqW'($urandom);
      1: it.request_bits = ReqW'($urandom & $urandom & $urandom);
      2: it.request_bits = ReqW'($urandom | $urandom);
      default: it.request_bits = ReqW'(1) << $urandom_range(ReqW - 1);
    endcase
    it.input_active = ($urandom_range(2) == 0) ? '1 : NumFields'($urandom);
    it.credit_home  = pick_credit();
    it.credit_port1 = pick_credit();
    it.credit_port2 = pick_credit();
    it.credit_port3 = pick_credit();
    it.credit_port4 = pick_credit();
    return it;
  endfunction

  // credits are {home, port1, port2, port3, port4}, one hex digit each
  task automatic add_row(input bit cls, input logic [ReqW-1:0] req,
                         input logic [NumFields-1:0] act, input logic [19:0] credits,
                         input bit typed, input logic [NumFields-1:0] gv,
                         input logic [NumFields*SrcW-1:0] gs);
    dir_row_t row;
    row.item  = {cls, req, act, credits};
    row.typed = typed;
    row.grant = {gv, gs};
    dir_tab.push_back(row);
  endtask

  // one input transaction, entered and left at a falling edge
  task automatic send_round(input wfa_in_t item);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  // sender quiet until every owed grant has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending_grants.size() != 0);
  endtask

  // receiver: random stall, or a counted hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // check results, then record the round accepted at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (pending_grants.size() == 0) begin
          $error("unexpected result: grant_valid %b grant_source %h",
                 out_data.grant_valid, out_data.grant_source);
          mismatch_cnt++;
        end else begin
          want_grant = pending_grants.pop_front();
          if (out_data.grant_valid !== want_grant.grant_valid) begin
            $error("grant_valid: expected %b, actual %b",
                   want_grant.grant_valid, out_data.grant_valid);
            mismatch_cnt++;
          end
          if (out_data.grant_source !== want_grant.grant_source) begin
            $error("grant_source: expected %h, actual %h",
                   want_grant.grant_source, out_data.grant_source);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        pred_grant = allocate_round(in_data);
        pending_grants.push_back(row_typed ? row_grant : pred_grant);
      end
    end
  end

  initial begin
    foreach (class_prio[c]) class_prio[c] = '0;

    // all quiet
    add_row(1'b0, '0, '0, 20'h00000, 1'b1, '0, '0);
    // full matrix from diagonal 0: out0<-0, out1<-4, out2<-3, out3<-2, out4<-1
    add_row(1'b0, '1, '1, 20'hFFFFF, 1'b1, 5'h1F, 15'd5344);
    // request class at home with a single credit
    add_row(1'b0, 25'h0000001, 5'h01, 20'h1FFFF, 1'b1, '0, '0);
    // other class at home with a single credit
    add_row(1'b1, 25'h0000001, 5'h01, 20'h1FFFF, 1'b1, 5'h01, '0);
    // requests from inactive inputs
    add_row(1'b0, '1, '0, 20'hFFFFF, 1'b1, '0, '0);
    // no credits anywhere
    add_row(1'b0, '1, '1, 20'h00000, 1'b1, '0, '0);
    add_row(1'b1, '1, '1, 20'h00000, 1'b1, '0, '0);
    // rotated priorities and assorted patterns
    add_row(1'b0, '1, '1, 20'hFFFFF, 1'b0, '0, '0);
    add_row(1'b1, '1, '1, 20'hFFFFF, 1'b0, '0, '0);
    add_row(1'b0, 25'h0108421, '1, 20'h20000, 1'b0, '0, '0);
    add_row(1'b1, 25'h0108421, '1, 20'h10000, 1'b0, '0, '0);
    add_row(1'b0, 25'h0108421, '1, 20'h10000, 1'b0, '0, '0);
    add_row(1'b0, 25'h1555555, 5'h15, 20'h12345, 1'b0, '0, '0);
    add_row(1'b1, 25'h0AAAAAA, 5'h0A, 20'h54321, 1'b0, '0, '0);
    add_row(1'b0, 25'h1000000, 5'h10, 20'h0000F, 1'b0, '0, '0);
    add_row(1'b1, 25'h1F00000, 5'h10, 20'hF0F0F, 1'b0, '0, '0);
    add_row(1'b0, 25'h000001F, 5'h01, 20'hEDCBA, 1'b0, '0, '0);
    add_row(1'b0, '1, '1, 20'h2EEEE, 1'b0, '0, '0);
    add_row(1'b1, 25'h0842108, '1, 20'hF1111, 1'b0, '0, '0);
    add_row(1'b0, '1, 5'h1B, 20'h30303, 1'b0, '0, '0);
    add_row(1'b1, '1, 5'h04, 20'h88888, 1'b0, '0, '0);

    // reset
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (dir_tab[i]) begin
      row_typed = dir_tab[i].typed;
      row_grant = dir_tab[i].grant;
      send_round(dir_tab[i].item);
    end
    row_typed = 1'b0;
    wait_idle();

    // random rounds under three idling mixes
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          in_idle_pct  = 28;
          out_idle_pct = 53;
        end
        1: begin
          in_idle_pct  = 53;
          out_idle_pct = 28;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
          // output held off while rounds keep coming
          hold_req = 1'b1;
        end
      endcase
      repeat (RoundsPerPhase) send_round(rand_round());
      wait_idle();
    end

    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
